// ===== hdl/fcull_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_pkg
// Shared widths, defaults and register codes for the box frustum cull unit.
// ----------------------------------------------------------------------------
package fcull_pkg;

   // Width of one fixed-point input field or matrix entry
   localparam int DATA_W = 32;

   // Default number of fraction bits (Q16.16)
   localparam int FRAC_BITS_DEF = 16;

   // Fog scale is 1 + FOG_NUM / FOG_DEN, rounded to the fraction width
   localparam int FOG_NUM = 7;
   localparam int FOG_DEN = 10000;

   // Matrix register count and index width
   localparam int CSR_COUNT = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 2 * DATA_W;

   // Matrix register map: two entries per register, lower column in low half
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW1_COLS12 = 3'd0,
      REG_ROW1_COLS34 = 3'd1,
      REG_ROW2_COLS12 = 3'd2,
      REG_ROW2_COLS34 = 3'd3,
      REG_ROW3_COLS12 = 3'd4,
      REG_ROW3_COLS34 = 3'd5,
      REG_ROW4_COLS12 = 3'd6,
      REG_ROW4_COLS34 = 3'd7
   } csr_index_type;

endpackage

// ===== hdl/fcull_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_mul
// Product stage: forms every corner and extent product with the matrix and
// truncates each toward minus infinity.
// ----------------------------------------------------------------------------
module fcull_mul #(
   parameter int FRAC_BITS = fcull_pkg::FRAC_BITS_DEF,
   localparam int DW = fcull_pkg::DATA_W,
   localparam int PROD_W = 2 * DW - FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [DW-1:0]     vec [4],
   input  logic signed [DW-1:0]     ext [3],
   input  logic signed [DW-1:0]     mat [4][4],
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [PROD_W-1:0] base_prod [4][4],
   output logic signed [PROD_W-1:0] offs_prod [3][4]
);

   logic                     vld_ff;
   logic signed [PROD_W-1:0] base_in [4][4];
   logic signed [PROD_W-1:0] offs_in [3][4];
   logic signed [PROD_W-1:0] base_ff [4][4];
   logic signed [PROD_W-1:0] offs_ff [3][4];

   // Take a new transaction when empty or when the next stage moves on
   assign in_ready = !vld_ff || out_ready;

   // Base corner products: dropping the low fraction bits floors the result
   for (genvar gr = 0; gr < 4; gr++) begin : g_base_r
      for (genvar gc = 0; gc < 4; gc++) begin : g_base_c
         logic signed [2*DW-1:0] prod;
         assign prod = vec[gr] * mat[gr][gc];
         assign base_in[gr][gc] = prod[2*DW-1:FRAC_BITS];
      end
   end

   // Extent products against the first three rows
   for (genvar gr = 0; gr < 3; gr++) begin : g_offs_r
      for (genvar gc = 0; gc < 4; gc++) begin : g_offs_c
         logic signed [2*DW-1:0] prod;
         assign prod = ext[gr] * mat[gr][gc];
         assign offs_in[gr][gc] = prod[2*DW-1:FRAC_BITS];
      end
   end

   // Stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   // Stage payload: load only on an accepted transaction
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         base_ff <= base_in;
         offs_ff <= offs_in;
      end
   end

   assign out_valid = vld_ff;
   assign base_prod = base_ff;
   assign offs_prod = offs_ff;

endmodule

// ===== hdl/fcull_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_sum
// Two sum stages: the transformed base corner, then all eight box corners
// built from the base and the selected row offsets.
// ----------------------------------------------------------------------------
module fcull_sum #(
   parameter int FRAC_BITS = fcull_pkg::FRAC_BITS_DEF,
   localparam int DW = fcull_pkg::DATA_W,
   localparam int PROD_W = 2 * DW - FRAC_BITS,
   localparam int SUM_W = PROD_W + 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic signed [PROD_W-1:0] base_prod [4][4],
   input  logic signed [PROD_W-1:0] offs_prod [3][4],
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic signed [SUM_W-1:0]  corner [8][4]
);

   logic                    base_vld_ff;
   logic                    base_ready;
   logic signed [SUM_W-1:0] base_in [4];
   logic signed [SUM_W-1:0] base_ff [4];
   logic signed [SUM_W-1:0] offs_in [3][4];
   logic signed [SUM_W-1:0] offs_ff [3][4];
   logic                    corner_vld_ff;
   logic                    corner_ready;
   logic signed [SUM_W-1:0] corner_in [8][4];
   logic signed [SUM_W-1:0] corner_ff [8][4];

   // Back-pressure chain through both stages
   assign corner_ready = !corner_vld_ff || out_ready;
   assign base_ready   = !base_vld_ff || corner_ready;
   assign in_ready     = base_ready;

   // Sum the four base products per column; extend the offsets
   for (genvar gc = 0; gc < 4; gc++) begin : g_base
      assign base_in[gc] = SUM_W'(base_prod[0][gc]) + SUM_W'(base_prod[1][gc])
                         + SUM_W'(base_prod[2][gc]) + SUM_W'(base_prod[3][gc]);
      for (genvar gr = 0; gr < 3; gr++) begin : g_offs
         assign offs_in[gr][gc] = SUM_W'(offs_prod[gr][gc]);
      end
   end

   // Corner k adds row 1, 2 and 3 offsets where bit 0, 1 and 2 of k are set
   for (genvar gk = 0; gk < 8; gk++) begin : g_corner
      for (genvar gc = 0; gc < 4; gc++) begin : g_col
         logic signed [SUM_W-1:0] add_x;
         logic signed [SUM_W-1:0] add_y;
         logic signed [SUM_W-1:0] add_z;
         assign add_x = ((gk & 1) != 0) ? offs_ff[0][gc] : '0;
         assign add_y = ((gk & 2) != 0) ? offs_ff[1][gc] : '0;
         assign add_z = ((gk & 4) != 0) ? offs_ff[2][gc] : '0;
         assign corner_in[gk][gc] = (base_ff[gc] + add_x) + (add_y + add_z);
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         base_vld_ff   <= 1'b0;
         corner_vld_ff <= 1'b0;
      end else begin
         if (base_ready) begin
            base_vld_ff <= in_valid;
         end
         if (corner_ready) begin
            corner_vld_ff <= base_vld_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (base_ready && in_valid) begin
         base_ff <= base_in;
         offs_ff <= offs_in;
      end
      if (corner_ready && base_vld_ff) begin
         corner_ff <= corner_in;
      end
   end

   assign out_valid = corner_vld_ff;
   assign corner    = corner_ff;

endmodule

// ===== hdl/fcull_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcull_clip
// Fog scale of each corner depth, then the strict six-plane clip test and
// the all-corners-outside-one-plane reduction into the result register.
// ----------------------------------------------------------------------------
module fcull_clip #(
   parameter int FRAC_BITS = fcull_pkg::FRAC_BITS_DEF,
   localparam int DW = fcull_pkg::DATA_W,
   localparam int PROD_W = 2 * DW - FRAC_BITS,
   localparam int SUM_W = PROD_W + 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [SUM_W-1:0] corner [8][4],
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic                    culled
);

   // Fraction part of the fog constant, rounded to nearest
   localparam int FOG_FRAC = ((fcull_pkg::FOG_NUM << FRAC_BITS) + fcull_pkg::FOG_DEN / 2)
                             / fcull_pkg::FOG_DEN;
   localparam int KW       = $clog2(FOG_FRAC + 2) + 1;
   localparam logic signed [KW-1:0] FOG_K = KW'(FOG_FRAC);
   localparam int ZK_W     = SUM_W + KW;
   localparam int FOG_W    = SUM_W + 1;
   localparam int CMP_W    = FOG_W + 1;

   logic                    fog_vld_ff;
   logic                    fog_ready;
   logic signed [SUM_W-1:0] x_ff [8];
   logic signed [SUM_W-1:0] y_ff [8];
   logic signed [SUM_W-1:0] w_ff [8];
   logic signed [FOG_W-1:0] z_in [8];
   logic signed [FOG_W-1:0] z_ff [8];
   logic                    res_vld_ff;
   logic                    res_ready;
   logic [7:0]              out_lo [3];
   logic [7:0]              out_hi [3];
   logic [5:0]              plane_all;
   logic                    culled_in;
   logic                    culled_ff;

   assign res_ready = !res_vld_ff || out_ready;
   assign fog_ready = !fog_vld_ff || res_ready;
   assign in_ready  = fog_ready;

   // Scale depth by 1 + FOG_K / 2^FRAC_BITS, floored exactly
   for (genvar gk = 0; gk < 8; gk++) begin : g_fog
      logic signed [ZK_W-1:0] zk;
      logic signed [ZK_W-1:0] part;
      assign zk   = ZK_W'(corner[gk][2]) * FOG_K;
      assign part = zk >>> FRAC_BITS;
      assign z_in[gk] = FOG_W'(corner[gk][2]) + part[FOG_W-1:0];
   end

   // Strict plane tests: inside when -w <= coordinate <= w
   for (genvar gk = 0; gk < 8; gk++) begin : g_test
      logic signed [CMP_W-1:0] pos_w;
      logic signed [CMP_W-1:0] neg_w;
      logic signed [CMP_W-1:0] coord [3];
      assign pos_w    = CMP_W'(w_ff[gk]);
      assign neg_w    = -pos_w;
      assign coord[0] = CMP_W'(x_ff[gk]);
      assign coord[1] = CMP_W'(y_ff[gk]);
      assign coord[2] = CMP_W'(z_ff[gk]);
      for (genvar gc = 0; gc < 3; gc++) begin : g_axis
         assign out_lo[gc][gk] = coord[gc] < neg_w;
         assign out_hi[gc][gk] = coord[gc] > pos_w;
      end
   end

   // Cull when every corner is beyond one and the same plane
   for (genvar gc = 0; gc < 3; gc++) begin : g_plane
      assign plane_all[2*gc]     = &out_lo[gc];
      assign plane_all[2*gc + 1] = &out_hi[gc];
   end
   assign culled_in = |plane_all;

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         fog_vld_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         if (fog_ready) begin
            fog_vld_ff <= in_valid;
         end
         if (res_ready) begin
            res_vld_ff <= fog_vld_ff;
         end
      end
   end

   // Stage payloads
   always_ff @(posedge clock) begin
      if (fog_ready && in_valid) begin
         for (int k = 0; k < 8; k++) begin
            x_ff[k] <= corner[k][0];
            y_ff[k] <= corner[k][1];
            w_ff[k] <= corner[k][3];
         end
         z_ff <= z_in;
      end
      if (res_ready && fog_vld_ff) begin
         culled_ff <= culled_in;
      end
   end

   assign out_valid = res_vld_ff;
   assign culled    = culled_ff;

endmodule

// ===== hdl/aabb_frustum_cull_test_unit.sv =====
`timescale 1ns / 1ps
// Stages from an accepted request to rsp_valid: product, base sum, corner
// sum, fog scale, clip test with result register. Reset clears all stage
// valids and the matrix to zero. Throughput: one box per cycle while
// rsp_stall is low; the 28 parallel 32x32 multipliers of the product stage
// set that figure. Stalls back up stage by stage, empty stages keep filling.
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// Clip-space frustum cull test of one axis-aligned box against a configured
// view-projection matrix, in signed fixed point.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_unit #(
   parameter int FRAC_BITS = fcull_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_corner_x,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_corner_y,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_corner_z,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_corner_w,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_size_x,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_size_y,
   input  logic signed [fcull_pkg::DATA_W-1:0]    req_size_z,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_culled,
   // matrix register write channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [fcull_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fcull_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int DW     = fcull_pkg::DATA_W;
   localparam int PROD_W = 2 * DW - FRAC_BITS;
   localparam int SUM_W  = PROD_W + 3;

   logic [fcull_pkg::CSR_DATA_W-1:0] csr_ff [fcull_pkg::CSR_COUNT];

   logic signed [DW-1:0]     vec [4];
   logic signed [DW-1:0]     ext [3];
   logic signed [DW-1:0]     mat [4][4];
   logic                     mul_in_ready;
   logic                     mul_valid;
   logic                     sum_in_ready;
   logic signed [PROD_W-1:0] base_prod [4][4];
   logic signed [PROD_W-1:0] offs_prod [3][4];
   logic                     sum_valid;
   logic                     clip_in_ready;
   logic signed [SUM_W-1:0]  corner [8][4];

   // Matrix registers: always ready, written by index
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fcull_pkg::CSR_COUNT; i++) begin
            csr_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         csr_ff[csr_index] <= csr_data;
      end
   end

   // Unpack entry (r, c) from register 2r + c/2, lower column in low half
   for (genvar gr = 0; gr < 4; gr++) begin : g_mat_r
      for (genvar gc = 0; gc < 4; gc++) begin : g_mat_c
         assign mat[gr][gc] = csr_ff[2*gr + gc/2][(gc%2)*DW +: DW];
      end
   end

   // Gather the request fields
   assign vec[0] = req_corner_x;
   assign vec[1] = req_corner_y;
   assign vec[2] = req_corner_z;
   assign vec[3] = req_corner_w;
   assign ext[0] = req_size_x;
   assign ext[1] = req_size_y;
   assign ext[2] = req_size_z;

   assign req_stall = !mul_in_ready;

   fcull_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (mul_in_ready),
      .vec       (vec),
      .ext       (ext),
      .mat       (mat),
      .out_valid (mul_valid),
      .out_ready (sum_in_ready),
      .base_prod (base_prod),
      .offs_prod (offs_prod)
   );

   fcull_sum #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mul_valid),
      .in_ready  (sum_in_ready),
      .base_prod (base_prod),
      .offs_prod (offs_prod),
      .out_valid (sum_valid),
      .out_ready (clip_in_ready),
      .corner    (corner)
   );

   fcull_clip #(
      .FRAC_BITS (FRAC_BITS)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (clip_in_ready),
      .corner    (corner),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .culled    (rsp_culled)
   );

endmodule
